/* src/qlsf_pkg.sv */
`default_nettype none
package qlsf_pkg;

    localparam int COORD_BITS = 11;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 32;
    localparam int COEF_BITS  = 64;

    localparam int S0_BITS = COUNT_BITS;
    localparam int S1_BITS = COUNT_BITS + COORD_BITS;
    localparam int S2_BITS = COUNT_BITS + 2 * COORD_BITS;
    localparam int S3_BITS = COUNT_BITS + 3 * COORD_BITS;
    localparam int S4_BITS = COUNT_BITS + 4 * COORD_BITS;
    localparam int T0_BITS = COUNT_BITS + COORD_BITS;
    localparam int T1_BITS = COUNT_BITS + 2 * COORD_BITS;
    localparam int T2_BITS = COUNT_BITS + 3 * COORD_BITS;

    // exact range of the cofactor products plus the fraction shift and headroom
    localparam int WIDE_BITS = 3 * COUNT_BITS + 7 * COORD_BITS + FRAC_BITS + 8;
    localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

    localparam int REG_DEPTH = 16;
    localparam int ADDR_BITS = $clog2(REG_DEPTH);
    localparam int NUM_SRC   = 8;
    localparam int SRC_BITS  = $clog2(NUM_SRC);
    localparam int LEAD_LEN  = 3;
    localparam int DET_LEN   = 14;
    localparam int TZ_BASE   = LEAD_LEN + 4 * DET_LEN;
    localparam int DIV_BASE  = TZ_BASE + 3;
    localparam int PROG_LEN  = DIV_BASE + 3;
    localparam int PC_BITS   = $clog2(PROG_LEN);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [ADDR_BITS-1:0] addr_t;

    localparam addr_t R_S0   = 4'd0;
    localparam addr_t R_S1   = 4'd1;
    localparam addr_t R_S2   = 4'd2;
    localparam addr_t R_S3   = 4'd3;
    localparam addr_t R_S4   = 4'd4;
    localparam addr_t R_T0   = 4'd5;
    localparam addr_t R_T1   = 4'd6;
    localparam addr_t R_T2   = 4'd7;
    localparam addr_t R_LEAD = 4'd8;
    localparam addr_t R_DET  = 4'd9;
    localparam addr_t R_TA   = 4'd10;
    localparam addr_t R_TB   = 4'd11;
    localparam addr_t R_N0   = 4'd12;

    typedef enum logic [2:0] {OP_MUL, OP_ADD, OP_SUB, OP_TZ, OP_DIV} op_t;

    typedef struct packed {
        op_t   op;
        addr_t dst;
        addr_t src_a;
        addr_t src_b;
    } uinstr_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] indep_value;
        logic [COORD_BITS-1:0] dep_value;
        logic                  last;
    } point_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_const;
        logic signed [COEF_BITS-1:0] coef_linear;
        logic signed [COEF_BITS-1:0] coef_square;
        logic [1:0]                  status;
    } result_t;

    typedef struct packed {
        logic                load;
        logic                step1;
        logic                step2;
        logic                add;
        logic                clear;
        logic [SRC_BITS-1:0] sel;
    } acc_cmd_t;

    typedef struct packed {
        logic       start;
        op_t        op;
        logic [1:0] sel;
        logic       clr_zero;
    } eng_cmd_t;

    typedef struct packed {
        logic  we;
        logic  wsel_copy;
        addr_t waddr;
        addr_t raddr_a;
        addr_t raddr_b;
    } ram_cmd_t;

    function automatic uinstr_t mk(op_t op, addr_t d, addr_t a, addr_t b);
        uinstr_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    // entries of the 3x3 matrix, col 0..2 swaps in the moment column
    function automatic logic [9*ADDR_BITS-1:0] matrix(logic [1:0] col);
        addr_t m [9];
        logic [9*ADDR_BITS-1:0] p;
        m[0] = R_S0; m[1] = R_S1; m[2] = R_S2;
        m[3] = R_S1; m[4] = R_S2; m[5] = R_S3;
        m[6] = R_S2; m[7] = R_S3; m[8] = R_S4;
        if (col != 2'd3) begin
            m[col]        = R_T0;
            m[3 + 32'(col)] = R_T1;
            m[6 + 32'(col)] = R_T2;
        end
        for (int i = 0; i < 9; i++) begin
            p[i*ADDR_BITS +: ADDR_BITS] = m[i];
        end
        return p;
    endfunction

    function automatic uinstr_t det_step(logic [3:0] step, logic [9*ADDR_BITS-1:0] e,
                                         addr_t acc);
        addr_t m [9];
        for (int i = 0; i < 9; i++) begin
            m[i] = e[i*ADDR_BITS +: ADDR_BITS];
        end
        case (step)
            4'd0:    return mk(OP_MUL, R_TA, m[4], m[8]);
            4'd1:    return mk(OP_MUL, R_TB, m[5], m[7]);
            4'd2:    return mk(OP_SUB, R_TA, R_TA, R_TB);
            4'd3:    return mk(OP_MUL, acc, m[0], R_TA);
            4'd4:    return mk(OP_MUL, R_TA, m[3], m[8]);
            4'd5:    return mk(OP_MUL, R_TB, m[5], m[6]);
            4'd6:    return mk(OP_SUB, R_TA, R_TA, R_TB);
            4'd7:    return mk(OP_MUL, R_TA, m[1], R_TA);
            4'd8:    return mk(OP_SUB, acc, acc, R_TA);
            4'd9:    return mk(OP_MUL, R_TA, m[3], m[7]);
            4'd10:   return mk(OP_MUL, R_TB, m[4], m[6]);
            4'd11:   return mk(OP_SUB, R_TA, R_TA, R_TB);
            4'd12:   return mk(OP_MUL, R_TA, m[2], R_TA);
            default: return mk(OP_ADD, acc, acc, R_TA);
        endcase
    endfunction

    // solve program: leading minor, determinant, three numerators, zero tests, divides
    function automatic uinstr_t ucode(logic [PC_BITS-1:0] pc);
        logic [PC_BITS-1:0] rel;
        rel = pc - PC_BITS'(LEAD_LEN);
        if (pc == PC_BITS'(0)) begin
            return mk(OP_MUL, R_LEAD, R_S0, R_S2);
        end else if (pc == PC_BITS'(1)) begin
            return mk(OP_MUL, R_TB, R_S1, R_S1);
        end else if (pc == PC_BITS'(2)) begin
            return mk(OP_SUB, R_LEAD, R_LEAD, R_TB);
        end else if (rel < PC_BITS'(DET_LEN)) begin
            return det_step(rel[3:0], matrix(2'd3), R_DET);
        end else if (rel < PC_BITS'(2 * DET_LEN)) begin
            return det_step(4'(rel - PC_BITS'(DET_LEN)), matrix(2'd0), R_N0);
        end else if (rel < PC_BITS'(3 * DET_LEN)) begin
            return det_step(4'(rel - PC_BITS'(2 * DET_LEN)), matrix(2'd1),
                            addr_t'(R_N0 + 4'd1));
        end else if (rel < PC_BITS'(4 * DET_LEN)) begin
            return det_step(4'(rel - PC_BITS'(3 * DET_LEN)), matrix(2'd2),
                            addr_t'(R_N0 + 4'd2));
        end else if (pc == PC_BITS'(TZ_BASE)) begin
            return mk(OP_TZ, R_S0, R_S0, R_S0);
        end else if (pc == PC_BITS'(TZ_BASE + 1)) begin
            return mk(OP_TZ, R_LEAD, R_LEAD, R_LEAD);
        end else if (pc == PC_BITS'(TZ_BASE + 2)) begin
            return mk(OP_TZ, R_DET, R_DET, R_DET);
        end else if (pc == PC_BITS'(DIV_BASE)) begin
            return mk(OP_DIV, 4'd0, R_N0, R_DET);
        end else if (pc == PC_BITS'(DIV_BASE + 1)) begin
            return mk(OP_DIV, 4'd1, addr_t'(R_N0 + 4'd1), R_DET);
        end else begin
            return mk(OP_DIV, 4'd2, addr_t'(R_N0 + 4'd2), R_DET);
        end
    endfunction

endpackage
`default_nettype wire

/* src/quadratic_least_squares_fit.sv */
`default_nettype none
// quadratic least-squares fit of a point stream
// input: a point (indep_value, dep_value, last) is taken on a clock edge with start high
//   and busy low. busy stays high while the point passes through the three-stage
//   power/product pipeline feeding the accumulators.
// a point with last set starts the solve: the sums are copied into a 16-entry register
//   memory, then a fixed 65-step program runs on one shared wide unit with a bit-serial
//   multiplier and a restoring divider.
// output: one result beat per set, held for one cycle with result_strobe high. the
//   receiver cannot hold it off. status is ok, singular (coefficients zero) or count
//   overflow (coefficients zero). the accumulators clear on the result beat.
// points beyond the count limit are dropped and flag overflow for the set.
// reset: asynchronous, clears all sums, the overflow flag and the controller; busy is
//   low straight after reset.
module quadratic_least_squares_fit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire qlsf_pkg::point_t  point,
    output qlsf_pkg::result_t      result,
    output logic                   result_strobe
);

    localparam int W = qlsf_pkg::WIDE_BITS;

    qlsf_pkg::acc_cmd_t acc_cmd;
    qlsf_pkg::eng_cmd_t eng_cmd;
    qlsf_pkg::ram_cmd_t ram_cmd;

    logic         eng_done;
    logic         overflow_seen;
    logic         zero_seen;
    logic [W-1:0] sum_out;
    logic [W-1:0] eng_result;
    logic [W-1:0] wdata;
    logic [W-1:0] rdata_a, rdata_b;
    logic signed [qlsf_pkg::COEF_BITS-1:0] c0, c1, c2;

    qlsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last     (point.last),
        .eng_done (eng_done),
        .busy     (busy),
        .strobe   (result_strobe),
        .acc_cmd  (acc_cmd),
        .eng_cmd  (eng_cmd),
        .ram_cmd  (ram_cmd)
    );

    qlsf_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (acc_cmd),
        .point         (point),
        .overflow_seen (overflow_seen),
        .sum_out       (sum_out)
    );

    assign wdata = ram_cmd.wsel_copy ? sum_out : eng_result;

    qlsf_ram #(
        .WIDTH (W),
        .DEPTH (qlsf_pkg::REG_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_cmd.we),
        .waddr   (ram_cmd.waddr),
        .wdata   (wdata),
        .raddr_a (ram_cmd.raddr_a),
        .raddr_b (ram_cmd.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    qlsf_alu u_alu (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (eng_cmd),
        .opnd_a      (rdata_a),
        .opnd_b      (rdata_b),
        .result      (eng_result),
        .done        (eng_done),
        .zero_seen   (zero_seen),
        .coef_const  (c0),
        .coef_linear (c1),
        .coef_square (c2)
    );

    always_comb
    begin
        if (overflow_seen)
        begin
            result.status = qlsf_pkg::STATUS_OVERFLOW;
        end
        else if (zero_seen)
        begin
            result.status = qlsf_pkg::STATUS_SINGULAR;
        end
        else
        begin
            result.status = qlsf_pkg::STATUS_OK;
        end
        if (result.status == qlsf_pkg::STATUS_OK)
        begin
            result.coef_const  = c0;
            result.coef_linear = c1;
            result.coef_square = c2;
        end
        else
        begin
            result.coef_const  = '0;
            result.coef_linear = '0;
            result.coef_square = '0;
        end
    end

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result beat outside a solve");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !busy && !result_strobe)
        else $error("block not idle after result beat");

    a_zero_coefs: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.status != qlsf_pkg::STATUS_OK) |->
            result.coef_const == '0 && result.coef_linear == '0
            && result.coef_square == '0)
        else $error("non-zero coefficients on a failed fit");

endmodule
`default_nettype wire

/* src/qlsf_ram.sv */
`default_nettype none
module qlsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

/* src/qlsf_accum.sv */
`default_nettype none
module qlsf_accum (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire qlsf_pkg::acc_cmd_t                  cmd,
    input  wire qlsf_pkg::point_t                    point,
    output logic                                     overflow_seen,
    output logic [qlsf_pkg::WIDE_BITS-1:0]           sum_out
);

    localparam int C = qlsf_pkg::COORD_BITS;
    localparam int W = qlsf_pkg::WIDE_BITS;

    logic [C-1:0]   x_reg, y_reg;
    logic           skip_reg;
    logic [2*C-1:0] x2_reg, xy_reg;
    logic [3*C-1:0] x3_reg, x2y_reg;
    logic [4*C-1:0] x4_reg;

    logic [qlsf_pkg::S0_BITS-1:0] s0_reg;
    logic [qlsf_pkg::S1_BITS-1:0] s1_reg;
    logic [qlsf_pkg::S2_BITS-1:0] s2_reg;
    logic [qlsf_pkg::S3_BITS-1:0] s3_reg;
    logic [qlsf_pkg::S4_BITS-1:0] s4_reg;
    logic [qlsf_pkg::T0_BITS-1:0] t0_reg;
    logic [qlsf_pkg::T1_BITS-1:0] t1_reg;
    logic [qlsf_pkg::T2_BITS-1:0] t2_reg;
    logic                         ovf_reg;

    // power and product pipeline, one multiply deep per stage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= point.indep_value;
            y_reg <= point.dep_value;
        end
        if (cmd.step1)
        begin
            x2_reg <= (2*C)'(x_reg) * (2*C)'(x_reg);
            xy_reg <= (2*C)'(x_reg) * (2*C)'(y_reg);
        end
        if (cmd.step2)
        begin
            x3_reg  <= (3*C)'(x2_reg) * (3*C)'(x_reg);
            x2y_reg <= (3*C)'(x2_reg) * (3*C)'(y_reg);
            x4_reg  <= (4*C)'(x2_reg) * (4*C)'(x2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            s0_reg   <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            s3_reg   <= '0;
            s4_reg   <= '0;
            t0_reg   <= '0;
            t1_reg   <= '0;
            t2_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            skip_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            s0_reg   <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            s3_reg   <= '0;
            s4_reg   <= '0;
            t0_reg   <= '0;
            t1_reg   <= '0;
            t2_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                // count already at its limit: drop the point
                skip_reg <= (s0_reg == '1);
                if (s0_reg == '1)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.add && !skip_reg)
            begin
                s0_reg <= s0_reg + qlsf_pkg::S0_BITS'(1);
                s1_reg <= s1_reg + qlsf_pkg::S1_BITS'(x_reg);
                s2_reg <= s2_reg + qlsf_pkg::S2_BITS'(x2_reg);
                s3_reg <= s3_reg + qlsf_pkg::S3_BITS'(x3_reg);
                s4_reg <= s4_reg + qlsf_pkg::S4_BITS'(x4_reg);
                t0_reg <= t0_reg + qlsf_pkg::T0_BITS'(y_reg);
                t1_reg <= t1_reg + qlsf_pkg::T1_BITS'(xy_reg);
                t2_reg <= t2_reg + qlsf_pkg::T2_BITS'(x2y_reg);
            end
        end
    end

    always_comb
    begin
        case (cmd.sel)
            3'd0:    sum_out = W'(s0_reg);
            3'd1:    sum_out = W'(s1_reg);
            3'd2:    sum_out = W'(s2_reg);
            3'd3:    sum_out = W'(s3_reg);
            3'd4:    sum_out = W'(s4_reg);
            3'd5:    sum_out = W'(t0_reg);
            3'd6:    sum_out = W'(t1_reg);
            3'd7:    sum_out = W'(t2_reg);
            default: sum_out = '0;
        endcase
    end

    assign overflow_seen = ovf_reg;

endmodule
`default_nettype wire

/* src/qlsf_alu.sv */
`default_nettype none
module qlsf_alu (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire qlsf_pkg::eng_cmd_t                   cmd,
    input  wire logic [qlsf_pkg::WIDE_BITS-1:0]       opnd_a,
    input  wire logic [qlsf_pkg::WIDE_BITS-1:0]       opnd_b,
    output logic      [qlsf_pkg::WIDE_BITS-1:0]       result,
    output logic                                      done,
    output logic                                      zero_seen,
    output logic signed [qlsf_pkg::COEF_BITS-1:0]     coef_const,
    output logic signed [qlsf_pkg::COEF_BITS-1:0]     coef_linear,
    output logic signed [qlsf_pkg::COEF_BITS-1:0]     coef_square
);

    localparam int W  = qlsf_pkg::WIDE_BITS;
    localparam int CB = qlsf_pkg::COEF_BITS;
    localparam int NB = qlsf_pkg::CNT_BITS;

    typedef enum logic [2:0] {E_IDLE, E_MUL, E_DIV, E_RND, E_SAT} estate_t;

    estate_t       state_reg, state_next;
    logic          done_reg, done_next;
    logic          zero_reg, zero_next;
    logic [NB-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  opa_reg, opa_next;
    logic [W-1:0]  opb_reg, opb_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic          neg_reg, neg_next;
    logic [1:0]    sel_reg, sel_next;
    logic [CB-1:0] c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;

    logic [W-1:0]  abs_a, abs_b;
    logic [W:0]    rem_shift, rem_diff;
    logic          fits, rnd_up, pos_sat, neg_sat;
    logic [CB-1:0] fix;

    always_comb
    begin
        abs_a     = opnd_a[W-1] ? -opnd_a : opnd_a;
        abs_b     = opnd_b[W-1] ? -opnd_b : opnd_b;
        rem_shift = {rem_reg, opa_reg[W-1]};
        rem_diff  = rem_shift - {1'b0, opb_reg};
        fits      = rem_shift >= {1'b0, opb_reg};
        rnd_up    = {rem_reg, 1'b0} >= {1'b0, opb_reg};
        pos_sat   = |opa_reg[W-1:CB-1];
        neg_sat   = (|opa_reg[W-1:CB]) || (opa_reg[CB-1] && (|opa_reg[CB-2:0]));
        if (neg_reg)
        begin
            fix = neg_sat ? {1'b1, {(CB-1){1'b0}}} : -opa_reg[CB-1:0];
        end
        else
        begin
            fix = pos_sat ? {1'b0, {(CB-1){1'b1}}} : opa_reg[CB-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        sel_next   = sel_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        if (cmd.clr_zero)
        begin
            zero_next = 1'b0;
        end
        case (state_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op)
                        qlsf_pkg::OP_MUL:
                        begin
                            acc_next   = '0;
                            opa_next   = opnd_a;
                            opb_next   = opnd_b;
                            state_next = E_MUL;
                        end
                        qlsf_pkg::OP_ADD:
                        begin
                            acc_next  = opnd_a + opnd_b;
                            done_next = 1'b1;
                        end
                        qlsf_pkg::OP_SUB:
                        begin
                            acc_next  = opnd_a - opnd_b;
                            done_next = 1'b1;
                        end
                        qlsf_pkg::OP_TZ:
                        begin
                            zero_next = zero_reg | (opnd_a == '0);
                            done_next = 1'b1;
                        end
                        qlsf_pkg::OP_DIV:
                        begin
                            opa_next   = abs_a << qlsf_pkg::FRAC_BITS;
                            opb_next   = abs_b;
                            rem_next   = '0;
                            neg_next   = opnd_a[W-1] ^ opnd_b[W-1];
                            sel_next   = cmd.sel;
                            cnt_next   = NB'(W);
                            state_next = E_DIV;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            E_MUL:
            begin
                // shift-add, ends once the multiplier runs out of ones
                if (opb_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
            end
            E_DIV:
            begin
                // restoring divide, quotient bits shift into the dividend register
                rem_next = fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
                opa_next = {opa_reg[W-2:0], fits};
                cnt_next = cnt_reg - NB'(1);
                if (cnt_reg == NB'(1))
                begin
                    state_next = E_RND;
                end
            end
            E_RND:
            begin
                opa_next   = opa_reg + W'(rnd_up);
                state_next = E_SAT;
            end
            E_SAT:
            begin
                case (sel_reg)
                    2'd0:    c0_next = fix;
                    2'd1:    c1_next = fix;
                    default: c2_next = fix;
                endcase
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        sel_reg <= sel_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
    end

    assign result      = acc_reg;
    assign done        = done_reg;
    assign zero_seen   = zero_reg;
    assign coef_const  = c0_reg;
    assign coef_linear = c1_reg;
    assign coef_square = c2_reg;

endmodule
`default_nettype wire

/* src/qlsf_ctrl.sv */
`default_nettype none
module qlsf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               last,
    input  wire logic               eng_done,
    output logic                    busy,
    output logic                    strobe,
    output qlsf_pkg::acc_cmd_t      acc_cmd,
    output qlsf_pkg::eng_cmd_t      eng_cmd,
    output qlsf_pkg::ram_cmd_t      ram_cmd
);

    localparam int PB = qlsf_pkg::PC_BITS;
    localparam int SB = qlsf_pkg::SRC_BITS;

    typedef enum logic [3:0] {
        C_IDLE, C_PT1, C_PT2, C_PT3, C_COPY, C_FETCH, C_READ, C_EXEC, C_EMIT
    } cstate_t;

    cstate_t           state_reg;
    logic [PB-1:0]     pc_reg;
    logic [SB-1:0]     copy_reg;
    logic              last_reg;
    qlsf_pkg::uinstr_t instr;
    logic              writes;

    assign instr  = qlsf_pkg::ucode(pc_reg);
    assign writes = (instr.op == qlsf_pkg::OP_MUL) || (instr.op == qlsf_pkg::OP_ADD)
                    || (instr.op == qlsf_pkg::OP_SUB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            pc_reg    <= '0;
            copy_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        last_reg  <= last;
                        state_reg <= C_PT1;
                    end
                end
                C_PT1: state_reg <= C_PT2;
                C_PT2: state_reg <= C_PT3;
                C_PT3:
                begin
                    copy_reg  <= '0;
                    state_reg <= last_reg ? C_COPY : C_IDLE;
                end
                C_COPY:
                begin
                    copy_reg <= copy_reg + SB'(1);
                    if (copy_reg == '1)
                    begin
                        pc_reg    <= '0;
                        state_reg <= C_FETCH;
                    end
                end
                C_FETCH: state_reg <= C_READ;
                C_READ:  state_reg <= C_EXEC;
                C_EXEC:
                begin
                    if (eng_done)
                    begin
                        if (pc_reg == PB'(qlsf_pkg::PROG_LEN - 1))
                        begin
                            state_reg <= C_EMIT;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + PB'(1);
                            state_reg <= C_FETCH;
                        end
                    end
                end
                C_EMIT:  state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_comb
    begin
        acc_cmd.load  = (state_reg == C_IDLE) && start;
        acc_cmd.step1 = (state_reg == C_PT1);
        acc_cmd.step2 = (state_reg == C_PT2);
        acc_cmd.add   = (state_reg == C_PT3);
        acc_cmd.clear = (state_reg == C_EMIT);
        acc_cmd.sel   = copy_reg;

        eng_cmd.start    = (state_reg == C_READ);
        eng_cmd.op       = instr.op;
        eng_cmd.sel      = instr.dst[1:0];
        eng_cmd.clr_zero = (state_reg == C_COPY) && (copy_reg == '0);

        ram_cmd.wsel_copy = (state_reg == C_COPY);
        ram_cmd.we        = (state_reg == C_COPY)
                            || ((state_reg == C_EXEC) && eng_done && writes);
        ram_cmd.waddr     = (state_reg == C_COPY) ? qlsf_pkg::addr_t'(copy_reg) : instr.dst;
        ram_cmd.raddr_a   = instr.src_a;
        ram_cmd.raddr_b   = instr.src_b;
    end

    assign busy   = (state_reg != C_IDLE);
    assign strobe = (state_reg == C_EMIT);

endmodule
`default_nettype wire
